// ===== hdl/nct_pkg.sv =====
// Shared types and constants for the nearest centroid tracker.
// Used by nct_dist, nct_slots and nearest_centroid_tracker.
package nct_pkg;

    localparam int XY_W           = 12;
    localparam int MD_W           = 12;
    localparam int ABS_W          = 8;
    localparam int ID_W           = 32;
    localparam int ACT_OUT_W      = 5;
    localparam int CFG_W          = 12;
    localparam int COORD_MAX_W    = 16;
    localparam int DEF_MAX_SLOTS  = 16;
    localparam int DEF_COORD_BITS = 12;

    localparam logic [MD_W-1:0]  MD_RESET         = 12'd80;
    localparam logic [ABS_W-1:0] MAX_ABSENT_RESET = 8'd8;
    localparam logic [ABS_W-1:0] ABS_SAT          = 8'd255;

    localparam logic [0:0] REG_MATCH_DIST = 1'b0;
    localparam logic [0:0] REG_MAX_ABSENT = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [XY_W-1:0] x_pos;
        logic [XY_W-1:0] y_pos;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]      object_id;
        logic                 is_new;
        logic                 dropped;
        logic [ACT_OUT_W-1:0] active_count;
    } t_out;

    typedef struct packed {
        logic we_pos;
        logic we_abs;
        logic we_id;
        logic set_valid;
        logic clr_valid;
    } t_slot_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/nct_dist.sv =====
// Shared squared-distance unit: |a-b|^2 + |c-d|^2 in two register stages.
// Carries an opaque tag alongside each operand set. Uses nct_pkg.
module nct_dist
    import nct_pkg::*;
#(
    parameter int DW    = 12,
    parameter int TAG_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_a,
    input  logic [DW-1:0]     i_b,
    input  logic [DW-1:0]     i_c,
    input  logic [DW-1:0]     i_d,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_valid,
    output logic [2*DW:0]     o_dist,
    output logic [TAG_W-1:0]  o_tag
);

    logic             r_a_vld;
    logic [DW-1:0]    r_dx;
    logic [DW-1:0]    r_dy;
    logic [TAG_W-1:0] r_a_tag;
    logic             r_b_vld;
    logic [2*DW:0]    r_dist;
    logic [TAG_W-1:0] r_b_tag;
    logic [2*DW-1:0]  sq_x;
    logic [2*DW-1:0]  sq_y;

    assign sq_x = (2*DW)'(r_dx) * (2*DW)'(r_dx);
    assign sq_y = (2*DW)'(r_dy) * (2*DW)'(r_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);
        r_dy    <= (i_c >= i_d) ? (i_c - i_d) : (i_d - i_c);
        r_a_tag <= i_tag;
        r_dist  <= {1'b0, sq_x} + {1'b0, sq_y};
        r_b_tag <= r_a_tag;
    end

    assign o_valid = r_b_vld;
    assign o_dist  = r_dist;
    assign o_tag   = r_b_tag;

endmodule

// ===== hdl/nct_slots.sv =====
// Object table: valid flags in flops, centroid, absence count and id arrays
// with one registered read port and one write port. Uses nct_pkg.
module nct_slots
    import nct_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int IDX_W      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_W-1:0]      i_raddr,
    output logic                  o_rd_valid,
    output logic [COORD_BITS-1:0] o_rd_x,
    output logic [COORD_BITS-1:0] o_rd_y,
    output logic [ABS_W-1:0]      o_rd_abs,
    output logic [ID_W-1:0]       o_rd_id,
    input  t_slot_wr              i_wr,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [COORD_BITS-1:0] i_wx,
    input  logic [COORD_BITS-1:0] i_wy,
    input  logic [ABS_W-1:0]      i_wabs,
    input  logic [ID_W-1:0]       i_wid
);

    logic [MAX_SLOTS-1:0]  r_valid;
    logic [COORD_BITS-1:0] r_mem_x   [MAX_SLOTS];
    logic [COORD_BITS-1:0] r_mem_y   [MAX_SLOTS];
    logic [ABS_W-1:0]      r_mem_abs [MAX_SLOTS];
    logic [ID_W-1:0]       r_mem_id  [MAX_SLOTS];
    logic                  r_rd_valid;
    logic [COORD_BITS-1:0] r_rd_x;
    logic [COORD_BITS-1:0] r_rd_y;
    logic [ABS_W-1:0]      r_rd_abs;
    logic [ID_W-1:0]       r_rd_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.set_valid) begin
            r_valid[i_waddr] <= 1'b1;
        end else if (i_wr.clr_valid) begin
            r_valid[i_waddr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_pos) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
        end
        if (i_wr.we_abs) begin
            r_mem_abs[i_waddr] <= i_wabs;
        end
        if (i_wr.we_id) begin
            r_mem_id[i_waddr] <= i_wid;
        end
        r_rd_valid <= r_valid[i_raddr];
        r_rd_x     <= r_mem_x[i_raddr];
        r_rd_y     <= r_mem_y[i_raddr];
        r_rd_abs   <= r_mem_abs[i_raddr];
        r_rd_id    <= r_mem_id[i_raddr];
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_x     = r_rd_x;
    assign o_rd_y     = r_rd_y;
    assign o_rd_abs   = r_rd_abs;
    assign o_rd_id    = r_rd_id;

endmodule

// ===== hdl/nearest_centroid_tracker.sv =====
// Nearest centroid tracker: sequencer, config registers and result register.
// Detection: the result follows a serial slot scan through one table read port
// and the shared distance unit (3-stage lag), then a decide step.
// Aging tick: the result follows a serial pass over all slots. One item
// at a time. Sync reset clears valid flags, next id, count and config to defaults.
// Uses nct_pkg, nct_dist, nct_slots.
module nearest_centroid_tracker
    import nct_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in              i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 4);
    localparam int ACT_W = $clog2(MAX_SLOTS + 1);
    localparam int DW    = (COORD_BITS > MD_W) ? COORD_BITS : MD_W;
    localparam int D_W   = 2 * DW + 1;
    localparam int TAG_W = 2 + IDX_W + ID_W;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [MD_W-1:0]       r_match_dist;
    logic [ABS_W-1:0]      r_max_absent;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [ID_W-1:0]       r_next_id;
    logic [ACT_W-1:0]      r_active;

    logic                  r_s1_go;
    logic                  r_s1_thr;
    logic [IDX_W-1:0]      r_s1_idx;

    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [D_W-1:0]        r_best_d;
    logic [ID_W-1:0]       r_best_id;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic [D_W-1:0]        r_thr;

    logic [ID_W-1:0]       r_res_id;
    logic                  r_res_new;
    logic                  r_res_drop;
    logic                  r_out_vld;
    t_out                  r_out;

    logic                  in_xfer;
    logic [COORD_MAX_W-1:0] in_x_ext;
    logic [COORD_MAX_W-1:0] in_y_ext;
    logic                  issue_go;
    logic                  issue_thr;
    logic [IDX_W-1:0]      issue_idx;
    logic [IDX_W-1:0]      waddr;
    logic [ABS_W-1:0]      wabs;
    t_slot_wr              wr;
    logic                  is_match;
    logic                  load_out;

    logic                  rd_valid;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [ABS_W-1:0]      rd_abs;
    logic [ID_W-1:0]       rd_id;
    logic [ABS_W-1:0]      abs_inc;
    logic                  age_free;

    logic                  dist_in_vld;
    logic [DW-1:0]         op_a;
    logic [DW-1:0]         op_b;
    logic [DW-1:0]         op_c;
    logic [DW-1:0]         op_d;
    logic [TAG_W-1:0]      tag_in;
    logic                  dist_vld;
    logic [D_W-1:0]        sq_dist;
    logic [TAG_W-1:0]      tag_out;
    logic                  t_live;
    logic                  t_thr;
    logic [IDX_W-1:0]      t_idx;
    logic [ID_W-1:0]       t_id;
    logic                  better;
    logic [31:0]           act_ext;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign in_x_ext = COORD_MAX_W'(i_in_data.x_pos);
    assign in_y_ext = COORD_MAX_W'(i_in_data.y_pos);

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_dist <= MD_RESET;
            r_max_absent <= MAX_ABSENT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MATCH_DIST: r_match_dist <= i_cfg_wdata;
                REG_MAX_ABSENT: r_max_absent <= i_cfg_wdata[ABS_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_xfer) n_state = i_in_data.kind ? ST_AGE : ST_SCAN;
            ST_SCAN:   if (r_cnt == CNT_W'(MAX_SLOTS + 3)) n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_DONE;
            ST_AGE:    if (r_cnt == CNT_W'(MAX_SLOTS)) n_state = ST_DONE;
            ST_DONE:   if (!r_out_vld || !i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign is_match = r_found && (r_best_d <= r_thr);
    assign abs_inc  = (rd_abs == ABS_SAT) ? rd_abs : rd_abs + 1'b1;
    assign age_free = rd_valid && (abs_inc > r_max_absent);

    // outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        issue_go   = 1'b0;
        issue_thr  = 1'b0;
        issue_idx  = '0;
        wr         = '0;
        waddr      = r_s1_idx;
        wabs       = '0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_SCAN: begin
                issue_go  = (r_cnt <= CNT_W'(MAX_SLOTS));
                issue_thr = (r_cnt == '0);
                issue_idx = IDX_W'(r_cnt - 1'b1);
            end
            ST_AGE: begin
                issue_go  = (r_cnt < CNT_W'(MAX_SLOTS));
                issue_idx = IDX_W'(r_cnt);
                if (r_s1_go) begin
                    wr.we_abs    = rd_valid;
                    wr.clr_valid = age_free;
                    wabs         = abs_inc;
                end
            end
            ST_DECIDE: begin
                if (is_match) begin
                    waddr     = r_best_idx;
                    wr.we_pos = 1'b1;
                    wr.we_abs = 1'b1;
                end else if (r_free_found) begin
                    waddr        = r_free_idx;
                    wr.we_pos    = 1'b1;
                    wr.we_abs    = 1'b1;
                    wr.we_id     = 1'b1;
                    wr.set_valid = 1'b1;
                end
            end
            ST_DONE: begin
                load_out = !r_out_vld || !i_out_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_s1_go   <= 1'b0;
            r_next_id <= '0;
            r_active  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_go <= issue_go;
            if (in_xfer) begin
                r_cnt <= '0;
            end else if (r_state == ST_SCAN || r_state == ST_AGE) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == ST_DECIDE && !is_match && r_free_found) begin
                r_next_id <= r_next_id + 1'b1;
                r_active  <= r_active + 1'b1;
            end else if (r_state == ST_AGE && r_s1_go && age_free) begin
                r_active <= r_active - 1'b1;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // scan bookkeeping and result
    assign {t_live, t_thr, t_idx, t_id} = tag_out;
    assign better = !r_found || (sq_dist < r_best_d) ||
                    ((sq_dist == r_best_d) && (t_id < r_best_id));

    always_ff @(posedge i_clk) begin
        r_s1_thr <= issue_thr;
        r_s1_idx <= issue_idx;
        if (in_xfer) begin
            r_x          <= in_x_ext[COORD_BITS-1:0];
            r_y          <= in_y_ext[COORD_BITS-1:0];
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (dist_vld) begin
            if (t_thr) begin
                r_thr <= sq_dist;
            end else if (t_live) begin
                if (better) begin
                    r_found    <= 1'b1;
                    r_best_idx <= t_idx;
                    r_best_d   <= sq_dist;
                    r_best_id  <= t_id;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= t_idx;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_res_id   <= is_match ? r_best_id : (r_free_found ? r_next_id : '0);
            r_res_new  <= !is_match && r_free_found;
            r_res_drop <= !is_match && !r_free_found;
        end else if (r_state == ST_AGE) begin
            r_res_id   <= '0;
            r_res_new  <= 1'b0;
            r_res_drop <= 1'b0;
        end
        if (load_out) begin
            r_out.object_id    <= r_res_id;
            r_out.is_new       <= r_res_new;
            r_out.dropped      <= r_res_drop;
            r_out.active_count <= act_ext[ACT_OUT_W-1:0];
        end
    end

    assign act_ext = 32'(r_active);

    // operands for the distance unit; the first token squares match_distance
    assign dist_in_vld = r_s1_go && (r_state == ST_SCAN);
    assign op_a   = r_s1_thr ? DW'(r_match_dist) : DW'(r_x);
    assign op_b   = r_s1_thr ? '0 : DW'(rd_x);
    assign op_c   = r_s1_thr ? '0 : DW'(r_y);
    assign op_d   = r_s1_thr ? '0 : DW'(rd_y);
    assign tag_in = {rd_valid, r_s1_thr, r_s1_idx, rd_id};

    nct_slots #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_raddr    (issue_idx),
        .o_rd_valid (rd_valid),
        .o_rd_x     (rd_x),
        .o_rd_y     (rd_y),
        .o_rd_abs   (rd_abs),
        .o_rd_id    (rd_id),
        .i_wr       (wr),
        .i_waddr    (waddr),
        .i_wx       (r_x),
        .i_wy       (r_y),
        .i_wabs     (wabs),
        .i_wid      (r_next_id)
    );

    nct_dist #(
        .DW    (DW),
        .TAG_W (TAG_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_in_vld),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_c     (op_c),
        .i_d     (op_d),
        .i_tag   (tag_in),
        .o_valid (dist_vld),
        .o_dist  (sq_dist),
        .o_tag   (tag_out)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== sim/tb_nearest_centroid_tracker.sv =====
// Self-checking testbench for nearest_centroid_tracker: directed and random
// detections and frame ticks with its own tracker model and result scoreboard.
// Depends on nct_pkg and the nearest_centroid_tracker RTL.
`timescale 1ns / 100ps

module tb_nearest_centroid_tracker;
    import nct_pkg::*;

    localparam int   SLOTS     = DEF_MAX_SLOTS;
    localparam int   XY_MAX    = (1 << XY_W) - 1;
    localparam logic KIND_DET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             in_stall;
    logic             out_valid;
    t_out             out_data;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [0:0]       cfg_idx   = REG_MATCH_DIST;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // tracker model state
    logic             trk_valid  [SLOTS];
    logic [XY_W-1:0]  trk_x      [SLOTS];
    logic [XY_W-1:0]  trk_y      [SLOTS];
    logic [ABS_W-1:0] trk_absent [SLOTS];
    logic [ID_W-1:0]  trk_id     [SLOTS];
    logic [ID_W-1:0]  id_next;
    logic [MD_W-1:0]  match_dist;
    logic [ABS_W-1:0] absent_limit;

    t_out results_due[$];
    int   n_fail         = 0;
    bit   tx_idle        = 1'b1;
    bit   rx_idle        = 1'b1;
    int   rx_hold_cycles = 0;

    nearest_centroid_tracker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic t_out track_update(input t_in item);
        t_out            res;
        bit              found;
        int              best, free_idx, n;
        longint unsigned dx, dy, d, best_d;
        res = '0;
        if (item.kind == KIND_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (trk_valid[i]) begin
                    if (trk_absent[i] != ABS_SAT)
                        trk_absent[i] = trk_absent[i] + 1'b1;
                    if (trk_absent[i] > absent_limit)
                        trk_valid[i] = 1'b0;
                end
            end
        end else begin
            found    = 1'b0;
            best     = 0;
            best_d   = 0;
            free_idx = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!trk_valid[i]) begin
                    if (free_idx < 0)
                        free_idx = i;
                end else begin
                    dx = (item.x_pos >= trk_x[i]) ? item.x_pos - trk_x[i]
                                                  : trk_x[i] - item.x_pos;
                    dy = (item.y_pos >= trk_y[i]) ? item.y_pos - trk_y[i]
                                                  : trk_y[i] - item.y_pos;
                    d  = dx * dx + dy * dy;
                    if (!found || d < best_d ||
                        (d == best_d && trk_id[i] < trk_id[best])) begin
                        found  = 1'b1;
                        best   = i;
                        best_d = d;
                    end
                end
            end
            if (found && best_d <= longint'(match_dist) * longint'(match_dist)) begin
                trk_x[best]      = item.x_pos;
                trk_y[best]      = item.y_pos;
                trk_absent[best] = '0;
                res.object_id    = trk_id[best];
            end else if (free_idx >= 0) begin
                trk_valid[free_idx]  = 1'b1;
                trk_x[free_idx]      = item.x_pos;
                trk_y[free_idx]      = item.y_pos;
                trk_absent[free_idx] = '0;
                trk_id[free_idx]     = id_next;
                res.object_id        = id_next;
                res.is_new           = 1'b1;
                id_next              = id_next + 1'b1;
            end else begin
                res.dropped = 1'b1;
            end
        end
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (trk_valid[i])
                n++;
        res.active_count = n[ACT_OUT_W-1:0];
        return res;
    endfunction

    function automatic t_in mk_det(input int x, input int y);
        t_in it;
        it.kind  = KIND_DET;
        it.x_pos = x[XY_W-1:0];
        it.y_pos = y[XY_W-1:0];
        return it;
    endfunction

    function automatic t_in mk_tick();
        t_in it;
        it       = t_in'($urandom);
        it.kind  = KIND_TICK;
        return it;
    endfunction

    function automatic int clamp_xy(input int v);
        return (v < 0) ? 0 : ((v > XY_MAX) ? XY_MAX : v);
    endfunction

    function automatic int tx_gap();
        int r;
        if (!tx_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic send_item(input t_in item);
        int gap;
        gap = tx_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        results_due.insert(results_due.size(), track_update(item));
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MATCH_DIST)
            match_dist = val[MD_W-1:0];
        else
            absent_limit = val[ABS_W-1:0];
    endtask

    // upper data bits on the 8-bit register are junk and must be dropped
    task automatic set_config(input int md_val, input int absent);
        wait_results_done();
        write_reg(REG_MATCH_DIST, md_val);
        write_reg(REG_MAX_ABSENT, absent | ($urandom_range(15) << ABS_W));
    endtask

    // frames of detections: mostly jittered repeats of live tracks, some new
    // objects in a window, a few anywhere in the field
    task automatic run_tracking(input int n_items, input int tick_pct, input int near_pct,
                                input int jitter, input int area, input int grid);
        int live[$];
        int s, x, y;
        for (int k = 0; k < n_items; k++) begin
            live.delete();
            for (int i = 0; i < SLOTS; i++)
                if (trk_valid[i])
                    live.insert(live.size(), i);
            if ($urandom_range(99) < tick_pct) begin
                send_item(mk_tick());
            end else begin
                if (live.size() > 0 && $urandom_range(99) < near_pct) begin
                    s = live[$urandom_range(live.size() - 1)];
                    x = clamp_xy(int'(trk_x[s]) + int'($urandom_range(2 * jitter)) - jitter);
                    y = clamp_xy(int'(trk_y[s]) + int'($urandom_range(2 * jitter)) - jitter);
                end else if ($urandom_range(9) == 0) begin
                    x = $urandom_range(XY_MAX);
                    y = $urandom_range(XY_MAX);
                end else begin
                    x = $urandom_range(area - 1);
                    y = $urandom_range(area - 1);
                end
                if (grid > 1) begin
                    x = x - x % grid;
                    y = y - y % grid;
                end
                send_item(mk_det(x, y));
            end
        end
    endtask

    task automatic test_defaults_and_ties();
        send_item(mk_det(0, 0));
        send_item(mk_det(XY_MAX, XY_MAX));
        send_item(mk_det(0, 80));           // exactly at the match radius
        send_item(mk_det(0, 161));          // one pixel beyond it
        send_item(mk_det(100, 80));
        send_item(mk_det(50, 80));          // equidistant, lower id sits in lower slot
    endtask

    task automatic test_aging_and_full();
        set_config(80, 1);
        send_item(mk_tick());
        send_item(mk_det(100, 80));
        send_item(mk_tick());               // frees the stale entries
        send_item(mk_det(0, 80));           // reuses slot 0 with a newer id
        send_item(mk_det(50, 80));          // tie: older id in higher slot wins
        for (int k = 0; k < 14; k++)
            send_item(mk_det(300 + 250 * k, 3000));
        send_item(mk_det(XY_MAX, 0));       // table full
        send_item(mk_tick());
    endtask

    task automatic test_tracking_default();
        set_config(MD_RESET, MAX_ABSENT_RESET);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_tracking(120, 15, 70, 40, 4096, 1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_tracking(330, 15, 70, 40, 4096, 1);
    endtask

    task automatic test_exact_match();
        set_config(0, 0);
        run_tracking(150, 20, 60, 1, 8, 1);
    endtask

    task automatic test_grid_ties();
        set_config(40, 3);
        run_tracking(250, 15, 50, 24, 256, 16);
    endtask

    task automatic test_back_pressure();
        set_config(200, 6);
        rx_hold_cycles = 300;
        run_tracking(60, 15, 70, 60, 4096, 1);
        wait_results_done();
        run_tracking(40, 15, 70, 60, 4096, 1);
    endtask

    task automatic test_absent_saturation();
        set_config(XY_MAX, 255);
        for (int k = 0; k < 3; k++)
            send_item(mk_det($urandom_range(XY_MAX), $urandom_range(XY_MAX)));
        tx_idle = 1'b0;
        for (int k = 0; k < 270; k++)
            send_item(mk_tick());
        tx_idle = 1'b1;
        send_item(mk_det($urandom_range(XY_MAX), $urandom_range(XY_MAX)));
        set_config(XY_MAX, 254);
        send_item(mk_tick());
        send_item(mk_det($urandom_range(XY_MAX), $urandom_range(XY_MAX)));
    endtask

    task automatic test_random_settings();
        for (int r = 0; r < 4; r++) begin
            set_config($urandom_range((r == 0) ? XY_MAX : 300), $urandom_range(255));
            run_tracking(100, 10 + 5 * r, 70, 40, 4096, 1);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("result transfer with nothing outstanding: %p", out_data);
                n_fail++;
            end else begin
                want = results_due.pop_front();
                if (out_data.object_id !== want.object_id) begin
                    $error("object_id: expected %0d, got %0d", want.object_id,
                           out_data.object_id);
                    n_fail++;
                end
                if (out_data.is_new !== want.is_new) begin
                    $error("is_new: expected %0d, got %0d", want.is_new, out_data.is_new);
                    n_fail++;
                end
                if (out_data.dropped !== want.dropped) begin
                    $error("dropped: expected %0d, got %0d", want.dropped, out_data.dropped);
                    n_fail++;
                end
                if (out_data.active_count !== want.active_count) begin
                    $error("active_count: expected %0d, got %0d", want.active_count,
                           out_data.active_count);
                    n_fail++;
                end
            end
        end
    end

    initial begin : rx_stall_gen
        int run_left;
        int r;
        run_left = 0;
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                out_stall <= 1'b1;
                rx_hold_cycles--;
            end else if (!rx_idle) begin
                out_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(6);
                end else if (r < 96) begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(3);
                end else begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(80, 20);
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            trk_valid[i]  = 1'b0;
            trk_x[i]      = '0;
            trk_y[i]      = '0;
            trk_absent[i] = '0;
            trk_id[i]     = '0;
        end
        id_next      = '0;
        match_dist   = MD_RESET;
        absent_limit = MAX_ABSENT_RESET;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_defaults_and_ties();
        test_aging_and_full();
        test_tracking_default();
        test_exact_match();
        test_grid_ties();
        test_back_pressure();
        test_absent_saturation();
        test_random_settings();

        wait_results_done();
        repeat (SLOTS + 10) @(posedge clk);
        if (n_fail == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
